// ----- hw/rtl/timestamp_text_parser_core_defines.svh -----
// assertion macros for the timestamp text parser checker
// expects clk and rst_n in the scope of every use
`ifndef TIMESTAMP_TEXT_PARSER_CORE_DEFINES_SVH
`define TIMESTAMP_TEXT_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TSP_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define TSP_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tsp_pkg.sv -----
// shared types, constants and helper functions of the timestamp text parser
// no dependencies; every rtl file but the defines header refers to this package by scoped names
`default_nettype none

package tsp_pkg;

    // text length limit and position counter width
    localparam int MAX_TEXT_LEN = 24;
    localparam int POS_W        = 5;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_LEN);

    // fixed positions within the trimmed text
    localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
    localparam logic [POS_W-1:0] POS_SPACE   = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
    localparam logic [POS_W-1:0] LEN_SHORT   = 5'd16;
    localparam logic [POS_W-1:0] LEN_FULL    = 5'd19;
    localparam logic [POS_W-1:0] YEAR_END    = 5'd3;
    localparam logic [POS_W-1:0] MONTH_END   = 5'd6;
    localparam logic [POS_W-1:0] DAY_END     = 5'd9;
    localparam logic [POS_W-1:0] HOUR_END    = 5'd12;
    localparam logic [POS_W-1:0] MINUTE_END  = 5'd15;

    // character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // range limits
    localparam logic [6:0] MONTH_MAX      = 7'd12;
    localparam logic [6:0] HOUR_MAX       = 7'd23;
    localparam logic [6:0] MINUTE_MAX     = 7'd59;
    localparam logic [6:0] SECOND_MAX     = 7'd59;
    localparam logic [4:0] DAYS_LONG      = 5'd31;
    localparam logic [4:0] DAYS_SHORT     = 5'd30;
    localparam logic [4:0] DAYS_FEB_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB       = 5'd28;

    // record queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // error codes
    typedef enum logic [3:0] {
        ERR_NONE      = 4'd0,
        ERR_LENGTH    = 4'd1,
        ERR_SEPARATOR = 4'd2,
        ERR_NONDIGIT  = 4'd3,
        ERR_MONTH     = 4'd4,
        ERR_DAY       = 4'd5,
        ERR_HOUR      = 4'd6,
        ERR_MINUTE    = 4'd7,
        ERR_SECOND    = 4'd8
    } err_t;

    // input transaction
    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } text_t;

    // output transaction
    typedef struct packed {
        logic       time_valid;
        logic [3:0] error_code;
        logic [13:0] year_value;
        logic [6:0] month_value;
        logic [6:0] day_value;
        logic [6:0] hour_value;
        logic [6:0] minute_value;
        logic [6:0] second_value;
    } result_t;

    // fault flags gathered while scanning
    typedef struct packed {
        logic ov;
        logic sep;
        logic nd;
    } flags_t;

    // scanned text, handed from front to back
    typedef struct packed {
        flags_t           flags;
        logic [POS_W-1:0] pos;
        logic [13:0]      year;
        logic [6:0]       month;
        logic [6:0]       day;
        logic [6:0]       hour;
        logic [6:0]       minute;
        logic [6:0]       second;
        logic [1:0]       yhi_m4;
        logic [1:0]       ylo_m4;
        logic             ylo_zero;
    } rec_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // saturating position from a one-bit-wider sum
    function automatic logic [POS_W-1:0] sat_pos(input logic [POS_W:0] s);
        if (s > {1'b0, MAX_POS})
            return MAX_POS;
        return s[POS_W-1:0];
    endfunction

    // faults raised by character c at trimmed position p
    function automatic flags_t place_chk(input logic [POS_W-1:0] p, input logic [7:0] c);
        flags_t f;
        f = '0;
        if (p >= LEN_FULL)
            f.ov = 1'b1;
        else if ((p == POS_DASH_A) || (p == POS_DASH_B))
            f.sep = (c != CH_DASH);
        else if (p == POS_SPACE)
            f.sep = (c != CH_SPACE);
        else if ((p == POS_COLON_A) || (p == POS_COLON_B))
            f.sep = (c != CH_COLON);
        else
            f.nd = !is_digit(c);
        return f;
    endfunction

    // month length, with february depending on the leap-year flag
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: d = DAYS_SHORT;
            4'd2:                    d = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            default:                 d = DAYS_LONG;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tsp_front.sv -----
// front end: accepts characters, trims whitespace, checks layout, builds fields
// depends on tsp_pkg; pushes one scanned record per text into tsp_queue
`default_nettype none

module tsp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          text_valid,
    output logic               text_ready,
    input  tsp_pkg::text_t     text_data,
    input  wire logic          q_full,
    output logic               push,
    output tsp_pkg::rec_t      push_rec
);

    tsp_pkg::rec_t               rec_reg, rec_upd, rec_next;
    logic                        started_reg, started_next;
    logic [tsp_pkg::POS_W-1:0]   pend_reg, pend_next;
    tsp_pkg::flags_t             held_reg, held_next;

    logic                        accept;
    logic [tsp_pkg::POS_W-1:0]   eff;
    tsp_pkg::flags_t             chk;
    logic                        take;
    logic [3:0]                  dgt;

    // accept whenever the queue can take a finished record
    assign text_ready = !q_full;
    assign accept     = text_valid && text_ready;
    assign push       = accept && text_data.last_byte;
    assign push_rec   = rec_upd;

    // position of this character once held whitespace counts as text
    assign eff  = tsp_pkg::sat_pos({1'b0, rec_reg.pos} + {1'b0, pend_reg});
    assign chk  = tsp_pkg::place_chk(eff, text_data.char_byte);
    assign take = (chk == '0) && tsp_pkg::is_digit(text_data.char_byte);
    assign dgt  = text_data.char_byte[3:0];

    // scan update for one transaction
    always_comb
    begin
        rec_upd      = rec_reg;
        started_next = started_reg;
        pend_next    = pend_reg;
        held_next    = held_reg;
        if (accept)
        begin
            if (tsp_pkg::is_space(text_data.char_byte))
            begin
                // whitespace is held until more text shows it is inner
                if (started_reg)
                begin
                    held_next = held_reg | chk;
                    pend_next = tsp_pkg::sat_pos({1'b0, pend_reg} + 1'b1);
                end
            end
            else
            begin
                started_next  = 1'b1;
                pend_next     = '0;
                held_next     = '0;
                rec_upd.flags = rec_reg.flags | held_reg | chk;
                rec_upd.pos   = tsp_pkg::sat_pos({1'b0, eff} + 1'b1);
                if (take)
                begin
                    if (eff <= tsp_pkg::YEAR_END)
                    begin
                        rec_upd.year = rec_reg.year * 14'd10 + 14'(dgt);
                        // year mod 4 kept per digit pair for the leap test
                        case (eff[1:0])
                            2'd0: rec_upd.yhi_m4 = {dgt[0], 1'b0};
                            2'd1: rec_upd.yhi_m4 = rec_reg.yhi_m4 + dgt[1:0];
                            2'd2:
                            begin
                                rec_upd.ylo_m4   = {dgt[0], 1'b0};
                                rec_upd.ylo_zero = (dgt == 4'd0);
                            end
                            default:
                            begin
                                rec_upd.ylo_m4   = rec_reg.ylo_m4 + dgt[1:0];
                                rec_upd.ylo_zero = rec_reg.ylo_zero && (dgt == 4'd0);
                            end
                        endcase
                    end
                    else if (eff <= tsp_pkg::MONTH_END)
                        rec_upd.month = rec_reg.month * 7'd10 + 7'(dgt);
                    else if (eff <= tsp_pkg::DAY_END)
                        rec_upd.day = rec_reg.day * 7'd10 + 7'(dgt);
                    else if (eff <= tsp_pkg::HOUR_END)
                        rec_upd.hour = rec_reg.hour * 7'd10 + 7'(dgt);
                    else if (eff <= tsp_pkg::MINUTE_END)
                        rec_upd.minute = rec_reg.minute * 7'd10 + 7'(dgt);
                    else
                        rec_upd.second = rec_reg.second * 7'd10 + 7'(dgt);
                end
            end
        end
        rec_next = rec_upd;
        // a finished text clears the scan state for the next one
        if (push)
        begin
            rec_next     = '0;
            started_next = 1'b0;
            pend_next    = '0;
            held_next    = '0;
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg     <= '0;
            started_reg <= 1'b0;
            pend_reg    <= '0;
            held_reg    <= '0;
        end
        else
        begin
            rec_reg     <= rec_next;
            started_reg <= started_next;
            pend_reg    <= pend_next;
            held_reg    <= held_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsp_queue.sv -----
// short record queue decoupling the scanning front from the checking back
// depends on tsp_pkg for the record type and depth
`default_nettype none

module tsp_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  tsp_pkg::rec_t   push_rec,
    input  wire logic       pop,
    output logic            full,
    output logic            head_valid,
    output tsp_pkg::rec_t   head_rec
);

    tsp_pkg::rec_t                 mem_reg [tsp_pkg::QUEUE_DEPTH];
    logic [tsp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tsp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tsp_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                          do_push, do_pop;

    function automatic logic [tsp_pkg::QPTR_W-1:0] ptr_inc(
        input logic [tsp_pkg::QPTR_W-1:0] p);
        if (p == tsp_pkg::QPTR_W'(tsp_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign full       = (cnt_reg == tsp_pkg::QCNT_W'(tsp_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsp_back.sv -----
// back end: range checks on a scanned record and the registered result stage
// depends on tsp_pkg; pops records from tsp_queue
`default_nettype none

module tsp_back (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         head_valid,
    input  tsp_pkg::rec_t     head_rec,
    output logic              pop,
    output logic              result_valid,
    input  wire logic         result_ready,
    output tsp_pkg::result_t  result_data
);

    logic               out_valid_reg, out_valid_next;
    tsp_pkg::result_t   out_data_reg, out_data_next;
    tsp_pkg::result_t   res;
    tsp_pkg::err_t      err;
    logic               len_bad, month_ok, day_ok, leap;
    logic [4:0]         dim;

    // leap year from the two digit pairs of the year
    assign leap = head_rec.ylo_zero ? (head_rec.yhi_m4 == 2'd0) : (head_rec.ylo_m4 == 2'd0);
    assign dim  = tsp_pkg::days_in_month(head_rec.month[3:0], leap);

    assign len_bad  = head_rec.flags.ov ||
                      ((head_rec.pos != tsp_pkg::LEN_SHORT) &&
                       (head_rec.pos != tsp_pkg::LEN_FULL));
    assign month_ok = (head_rec.month != 7'd0) && (head_rec.month <= tsp_pkg::MONTH_MAX);
    assign day_ok   = (head_rec.day != 7'd0) && (head_rec.day <= {2'b00, dim});

    // first failing check wins
    always_comb
    begin
        if (len_bad)
            err = tsp_pkg::ERR_LENGTH;
        else if (head_rec.flags.sep)
            err = tsp_pkg::ERR_SEPARATOR;
        else if (head_rec.flags.nd)
            err = tsp_pkg::ERR_NONDIGIT;
        else if (!month_ok)
            err = tsp_pkg::ERR_MONTH;
        else if (!day_ok)
            err = tsp_pkg::ERR_DAY;
        else if (head_rec.hour > tsp_pkg::HOUR_MAX)
            err = tsp_pkg::ERR_HOUR;
        else if (head_rec.minute > tsp_pkg::MINUTE_MAX)
            err = tsp_pkg::ERR_MINUTE;
        else if (head_rec.second > tsp_pkg::SECOND_MAX)
            err = tsp_pkg::ERR_SECOND;
        else
            err = tsp_pkg::ERR_NONE;
    end

    // result fields, zero when the text failed
    always_comb
    begin
        res            = '0;
        res.error_code = err;
        if (err == tsp_pkg::ERR_NONE)
        begin
            res.time_valid   = 1'b1;
            res.year_value   = head_rec.year;
            res.month_value  = head_rec.month;
            res.day_value    = head_rec.day;
            res.hour_value   = head_rec.hour;
            res.minute_value = head_rec.minute;
            res.second_value = head_rec.second;
        end
    end

    // output register loads when empty or being drained
    assign pop = head_valid && (!out_valid_reg || result_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/timestamp_text_parser_core.sv -----
// top level of the timestamp text parser: front scanner, record queue, checker back end
// depends on tsp_pkg, tsp_front, tsp_queue and tsp_back
//
//   channel   direction  handshake                     payload
//   text      in         text_valid / text_ready       tsp_pkg::text_t (char_byte, last_byte)
//   result    out        result_valid / result_ready   tsp_pkg::result_t
//
// one character per cycle while text_ready is high; the front scanner updates its counters in the cycle of acceptance
// a result reaches result_valid through the record queue and then the output register after its last byte is accepted
// the two-entry record queue plus the output register let the scanner run on
// while results wait; text_ready falls only when the queue is full
// reset is asynchronous and active low; no memory clearing pass follows it
`default_nettype none

module timestamp_text_parser_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         text_valid,
    output logic              text_ready,
    input  tsp_pkg::text_t    text_data,
    output logic              result_valid,
    input  wire logic         result_ready,
    output tsp_pkg::result_t  result_data
);

    logic            q_full, push, pop, head_valid;
    tsp_pkg::rec_t   push_rec, head_rec;

    // character scanning
    tsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_ready (text_ready),
        .text_data  (text_data),
        .q_full     (q_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    // record queue
    tsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // range checks and result register
    tsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_rec     (head_rec),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/tsp_checker.sv -----
// port-level checker for timestamp_text_parser_core, attached by bind
// depends on tsp_pkg and timestamp_text_parser_core_defines.svh
`default_nettype none

`include "timestamp_text_parser_core_defines.svh"

module tsp_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              text_valid,
    input wire logic              text_ready,
    input tsp_pkg::text_t         text_data,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input tsp_pkg::result_t       result_data
);

    logic [2:0] pend_cnt_reg, pend_cnt_next;
    logic       txt_done, res_done;

    assign txt_done = text_valid && text_ready && text_data.last_byte;
    assign res_done = result_valid && result_ready;

    // texts finished but whose result has not yet been taken
    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        if (txt_done && !res_done)
            pend_cnt_next = pend_cnt_reg + 1'b1;
        else if (res_done && !txt_done)
            pend_cnt_next = pend_cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_cnt_reg <= '0;
        else
            pend_cnt_reg <= pend_cnt_next;
    end

    // a waiting result holds
    `TSP_CHK_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "result changed while stalled")

    // every result answers an earlier last byte
    `TSP_CHK_SAME(a_no_extra_result, res_done, pend_cnt_reg != 3'd0, "result without a finished text")

    // input stalls only while results are outstanding
    `TSP_CHK_SAME(a_ready_stall, !text_ready, pend_cnt_reg != 3'd0, "input stalled with nothing outstanding")

    // valid flag agrees with the error code, failed texts carry zero fields
    `TSP_CHK_SAME(a_valid_code, result_valid, (result_data.time_valid == (result_data.error_code == tsp_pkg::ERR_NONE)) && (result_data.time_valid || ((result_data.year_value == 14'd0) && (result_data.month_value == 7'd0) && (result_data.day_value == 7'd0) && (result_data.hour_value == 7'd0) && (result_data.minute_value == 7'd0) && (result_data.second_value == 7'd0))), "valid flag and fields disagree")

    // a good timestamp is in range
    `TSP_CHK_SAME(a_valid_range, result_valid && result_data.time_valid, (result_data.month_value >= 7'd1) && (result_data.month_value <= 7'd12) && (result_data.day_value >= 7'd1) && (result_data.day_value <= 7'd31) && (result_data.hour_value <= 7'd23) && (result_data.minute_value <= 7'd59) && (result_data.second_value <= 7'd59), "valid timestamp out of range")

endmodule

bind timestamp_text_parser_core tsp_checker u_tsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_data    (text_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

`default_nettype wire
